/* hw/rtl/rmad_pkg.sv */
package rmad_pkg;

   localparam int CAPACITY_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 32;
   localparam int POINT_W        = 32;
   localparam int OFFSET_W       = 32;
   localparam int SUM_W          = 48;
   localparam int STATUS_W       = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic ACTION_ADD   = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_BAL,
      ST_QUERY
   } state_type;

   // one operation per cycle on a sorted chain
   typedef struct packed {
      logic insert;
      logic push;
      logic pop;
   } chain_op_type;

endpackage

/* hw/rtl/rmad_if.sv */
interface rmad_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [31:0] new_value;
   logic [31:0] offset;

   modport source(output valid, output action, output new_value, output offset, input ready);
   modport sink(input valid, input action, input new_value, input offset, output ready);
endinterface

interface rmad_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] best_point;
   logic [47:0] min_value;
   logic [1:0]  status;

   modport source(output valid, output best_point, output min_value, output status, input ready);
   modport sink(input valid, input best_point, input min_value, input status, output ready);
endinterface

/* hw/rtl/rmad_cell.sv */
module rmad_cell #(
   parameter int W      = 32,
   parameter bit ASCEND = 1'b1
) (
   input  logic                  clock,
   input  rmad_pkg::chain_op_type op,
   input  logic signed [W-1:0]   new_val,
   input  logic signed [W-1:0]   prev_val,
   input  logic                  prev_occ,
   input  logic signed [W-1:0]   next_val,
   input  logic                  own_occ,
   output logic signed [W-1:0]   value
);
   import rmad_pkg::*;

   logic signed [W-1:0] value_ff;
   logic signed [W-1:0] value_in;

   function automatic logic ahead(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
      ahead = ASCEND ? (x <= y) : (x >= y);
   endfunction

   always_comb begin
      value_in = value_ff;
      priority if (op.insert) begin
         if (own_occ && ahead(value_ff, new_val)) begin
            value_in = value_ff;
         end else if (prev_occ && ahead(prev_val, new_val)) begin
            value_in = new_val;
         end else begin
            value_in = prev_val;
         end
      end else if (op.push) begin
         value_in = prev_val;
      end else if (op.pop) begin
         value_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

/* hw/rtl/rmad_chain.sv */
module rmad_chain #(
   parameter int W      = 32,
   parameter int DEPTH  = 513,
   parameter int CW     = 10,
   parameter bit ASCEND = 1'b1
) (
   input  logic                   clock,
   input  rmad_pkg::chain_op_type op,
   input  logic signed [W-1:0]    front_val,
   input  logic [CW-1:0]          count,
   output logic signed [W-1:0]    top
);
   import rmad_pkg::*;

   logic signed [W-1:0] vals [DEPTH];
   logic                occ  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [W-1:0] prev_v;
      logic signed [W-1:0] next_v;
      logic                prev_o;

      assign occ[i] = (CW'(i) < count);

      if (i == 0) begin : g_head
         // the new value itself stands in front of the head cell
         assign prev_v = front_val;
         assign prev_o = 1'b1;
      end else begin : g_body
         assign prev_v = vals[i-1];
         assign prev_o = occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_v = vals[i];
      end else begin : g_mid
         assign next_v = vals[i+1];
      end

      rmad_cell #(.W(W), .ASCEND(ASCEND)) u_cell (
         .clock   (clock),
         .op      (op),
         .new_val (front_val),
         .prev_val(prev_v),
         .prev_occ(prev_o),
         .next_val(next_v),
         .own_occ (occ[i]),
         .value   (vals[i])
      );
   end

   assign top = vals[0];
endmodule

/* hw/rtl/running_median_abs_deviation_top.sv */
// An add steps through insert, then rebalance; a full-store add and a query
// load the result register from their own state after acceptance.
// Requests do not overlap: an add spends insert and rebalance steps, a
// query or dropped add waits for its result to drain before another is taken.
// Reset: synchronous, clears counts, sums, state and result valid; cell
// contents stay undefined until written.
module running_median_abs_deviation_top #(
   parameter int CAPACITY   = rmad_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = rmad_pkg::VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rmad_req_if.sink   req_if,
   rmad_rsp_if.source rsp_if
);
   import rmad_pkg::*;

   localparam int HALF = CAPACITY / 2 + 1;
   localparam int CW   = $clog2(HALF + 1);
   localparam int TW   = $clog2(CAPACITY + 1);
   localparam int VB   = VALUE_BITS;

   state_type state_ff, state_in;

   logic signed [VB-1:0]       val_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic [CW-1:0]              lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic signed [SUM_W-1:0]    ls_ff, ls_in, us_ff, us_in, os_ff, os_in;
   logic                       out_valid_ff, out_valid_in;
   logic [POINT_W-1:0]         out_point_ff, out_point_in;
   logic [SUM_W-1:0]           out_min_ff, out_min_in;
   logic [STATUS_W-1:0]        out_status_ff, out_status_in;

   chain_op_type         lop, uop;
   logic signed [VB-1:0] lfront, ufront, ltop, utop, med;
   logic signed [SUM_W-1:0] val_ext, off_ext, ltop_ext, utop_ext, med_ext;
   logic [TW-1:0]        total;
   logic                 full, to_upper, accept;

   assign req_if.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign accept       = req_if.valid && req_if.ready;

   assign total    = TW'(lcnt_ff) + TW'(ucnt_ff);
   assign full     = (total >= TW'(CAPACITY));
   assign to_upper = (ucnt_ff != '0) && (val_ff >= utop);
   assign val_ext  = SUM_W'(val_ff);
   assign off_ext  = SUM_W'(off_ff);
   assign ltop_ext = SUM_W'(ltop);
   assign utop_ext = SUM_W'(utop);
   assign med      = (lcnt_ff == ucnt_ff) ? ltop : utop;
   assign med_ext  = SUM_W'(med);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = (req_if.action == ACTION_QUERY) ? ST_QUERY : ST_ADD;
         ST_ADD:   state_in = full ? ST_IDLE : ST_BAL;
         ST_BAL:   state_in = ST_IDLE;
         ST_QUERY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lop           = '0;
      uop           = '0;
      lfront        = val_ff;
      ufront        = val_ff;
      lcnt_in       = lcnt_ff;
      ucnt_in       = ucnt_ff;
      ls_in         = ls_ff;
      us_in         = us_ff;
      os_in         = os_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_point_in  = out_point_ff;
      out_min_in    = out_min_ff;
      out_status_in = out_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_ADD: begin
            if (full) begin
               out_valid_in  = 1'b1;
               out_point_in  = '0;
               out_min_in    = '0;
               out_status_in = STATUS_FULL;
            end else begin
               os_in = os_ff + off_ext;
               if (to_upper) begin
                  uop.insert = 1'b1;
                  ucnt_in    = ucnt_ff + 1'b1;
                  us_in      = us_ff + val_ext;
               end else begin
                  lop.insert = 1'b1;
                  lcnt_in    = lcnt_ff + 1'b1;
                  ls_in      = ls_ff + val_ext;
               end
            end
         end
         ST_BAL: begin
            // halves are ordered, so a moved top goes to the head of the other chain
            if (lcnt_ff > ucnt_ff) begin
               lop.pop  = 1'b1;
               uop.push = 1'b1;
               ufront   = ltop;
               lcnt_in  = lcnt_ff - 1'b1;
               ucnt_in  = ucnt_ff + 1'b1;
               ls_in    = ls_ff - ltop_ext;
               us_in    = us_ff + ltop_ext;
            end else if (ucnt_ff > lcnt_ff + 1'b1) begin
               uop.pop  = 1'b1;
               lop.push = 1'b1;
               lfront   = utop;
               ucnt_in  = ucnt_ff - 1'b1;
               lcnt_in  = lcnt_ff + 1'b1;
               us_in    = us_ff - utop_ext;
               ls_in    = ls_ff + utop_ext;
            end
         end
         ST_QUERY: begin
            out_valid_in = 1'b1;
            if (ucnt_ff == '0) begin
               out_point_in  = '0;
               out_min_in    = '0;
               out_status_in = STATUS_EMPTY;
            end else begin
               out_point_in  = POINT_W'(med);
               // L*m - U*m is zero for equal halves, -m otherwise
               out_min_in    = us_ff - ls_ff + os_ff
                             - ((lcnt_ff == ucnt_ff) ? '0 : med_ext);
               out_status_in = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lcnt_ff      <= '0;
         ucnt_ff      <= '0;
         ls_ff        <= '0;
         us_ff        <= '0;
         os_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcnt_ff      <= lcnt_in;
         ucnt_ff      <= ucnt_in;
         ls_ff        <= ls_in;
         us_ff        <= us_in;
         os_ff        <= os_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         val_ff <= req_if.new_value[VB-1:0];
         off_ff <= req_if.offset;
      end
      out_point_ff  <= out_point_in;
      out_min_ff    <= out_min_in;
      out_status_ff <= out_status_in;
   end

   rmad_chain #(.W(VB), .DEPTH(HALF), .CW(CW), .ASCEND(1'b0)) u_lower (
      .clock    (clock),
      .op       (lop),
      .front_val(lfront),
      .count    (lcnt_ff),
      .top      (ltop)
   );

   rmad_chain #(.W(VB), .DEPTH(HALF), .CW(CW), .ASCEND(1'b1)) u_upper (
      .clock    (clock),
      .op       (uop),
      .front_val(ufront),
      .count    (ucnt_ff),
      .top      (utop)
   );

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.best_point = out_point_ff;
   assign rsp_if.min_value  = out_min_ff;
   assign rsp_if.status     = out_status_ff;
endmodule
